// ===== rtl/indexed_bit_shift_rotate_unit_macros.svh =====
// assertion macros for the indexed bit shift rotate unit
`ifndef INDEXED_BIT_SHIFT_ROTATE_UNIT_MACROS_SVH
`define INDEXED_BIT_SHIFT_ROTATE_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define IBSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define IBSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ibsr_pkg.sv =====
// types, codes and constants shared by the indexed bit shift rotate unit
`timescale 1ns / 1ps

package ibsr_pkg;

    // flag bit positions, S Z Y H X P N C
    localparam int unsigned FLAG_S = 7;
    localparam int unsigned FLAG_Z = 6;
    localparam int unsigned FLAG_Y = 5;
    localparam int unsigned FLAG_H = 4;
    localparam int unsigned FLAG_X = 3;
    localparam int unsigned FLAG_P = 2;
    localparam int unsigned FLAG_N = 1;
    localparam int unsigned FLAG_C = 0;

    localparam logic [4:0] T_BIT   = 5'd20;
    localparam logic [4:0] T_OTHER = 5'd23;

    // register code that means memory only
    localparam logic [2:0] REG_MEM = 3'd6;

    typedef enum logic [1:0] {
        GRP_SHIFT = 2'd0,
        GRP_BIT   = 2'd1,
        GRP_RES   = 2'd2,
        GRP_SET   = 2'd3
    } group_t;

    typedef enum logic [2:0] {
        SH_RLC = 3'd0,
        SH_RRC = 3'd1,
        SH_RL  = 3'd2,
        SH_RR  = 3'd3,
        SH_SLA = 3'd4,
        SH_SRA = 3'd5,
        SH_SLL = 3'd6,
        SH_SRL = 3'd7
    } shift_op_t;

    typedef struct packed {
        logic [15:0]       index_base;
        logic signed [7:0] displacement;
        logic [7:0]        sub_opcode;
        logic [7:0]        mem_byte;
        logic [7:0]        flags_in;
    } cmd_t;

    typedef struct packed {
        logic [15:0] effective_address;
        logic [7:0]  mem_write_value;
        logic        reg_write_enable;
        logic [2:0]  reg_dest;
        logic [7:0]  reg_value;
        logic [7:0]  flags_out;
        logic [4:0]  t_states;
    } result_t;

endpackage

// ===== rtl/ibsr_addr.sv =====
// effective address adder: index base plus sign-extended displacement
`timescale 1ns / 1ps

module ibsr_addr
(
    input  logic [15:0]       index_base,
    input  logic signed [7:0] displacement,
    output logic [15:0]       effective_address
);

    logic [15:0] disp_ext;

    assign disp_ext          = {{8{displacement[7]}}, displacement};
    // wraps modulo 64k
    assign effective_address = index_base + disp_ext;

endmodule

// ===== rtl/ibsr_alu.sv =====
// bit, shift and rotate execution on the memory byte with flag generation
`timescale 1ns / 1ps

module ibsr_alu
(
    input  logic [7:0] sub_opcode,
    input  logic [7:0] mem_byte,
    input  logic [7:0] flags_in,
    output logic [7:0] mem_write_value,
    output logic       reg_write_enable,
    output logic [2:0] reg_dest,
    output logic [7:0] reg_value,
    output logic [7:0] flags_out,
    output logic [4:0] t_states
);

    ibsr_pkg::group_t    grp;
    ibsr_pkg::shift_op_t sh_op;
    logic [2:0]          low3;
    logic [7:0]          bit_mask;
    logic                cin;
    logic [7:0]          sh_res;
    logic                sh_carry;
    logic [7:0]          bit_test;

    assign grp      = ibsr_pkg::group_t'(sub_opcode[7:6]);
    assign sh_op    = ibsr_pkg::shift_op_t'(sub_opcode[5:3]);
    assign low3     = sub_opcode[2:0];
    assign bit_mask = 8'd1 << sub_opcode[5:3];
    assign cin      = flags_in[ibsr_pkg::FLAG_C];
    assign bit_test = mem_byte & bit_mask;
    assign reg_dest = low3;

    always_comb
    begin
        case (sh_op)
            ibsr_pkg::SH_RLC:
            begin
                sh_carry = mem_byte[7];
                sh_res   = {mem_byte[6:0], mem_byte[7]};
            end
            ibsr_pkg::SH_RRC:
            begin
                sh_carry = mem_byte[0];
                sh_res   = {mem_byte[0], mem_byte[7:1]};
            end
            ibsr_pkg::SH_RL:
            begin
                sh_carry = mem_byte[7];
                sh_res   = {mem_byte[6:0], cin};
            end
            ibsr_pkg::SH_RR:
            begin
                sh_carry = mem_byte[0];
                sh_res   = {cin, mem_byte[7:1]};
            end
            ibsr_pkg::SH_SLA:
            begin
                sh_carry = mem_byte[7];
                sh_res   = {mem_byte[6:0], 1'b0};
            end
            ibsr_pkg::SH_SRA:
            begin
                sh_carry = mem_byte[0];
                sh_res   = {mem_byte[7], mem_byte[7:1]};
            end
            ibsr_pkg::SH_SLL:
            begin
                sh_carry = mem_byte[7];
                sh_res   = {mem_byte[6:0], 1'b1};
            end
            default:
            begin
                sh_carry = mem_byte[0];
                sh_res   = {1'b0, mem_byte[7:1]};
            end
        endcase
    end

    always_comb
    begin
        mem_write_value  = mem_byte;
        reg_write_enable = 1'b0;
        reg_value        = 8'd0;
        flags_out        = flags_in;
        t_states         = ibsr_pkg::T_OTHER;
        case (grp)
            ibsr_pkg::GRP_SHIFT:
            begin
                mem_write_value = sh_res;
                flags_out       = {sh_res[7], (sh_res == 8'd0), sh_res[5], 1'b0,
                                   sh_res[3], ~(^sh_res), 1'b0, sh_carry};
                if (low3 != ibsr_pkg::REG_MEM)
                begin
                    reg_write_enable = 1'b1;
                    reg_value        = sh_res;
                end
            end
            ibsr_pkg::GRP_BIT:
            begin
                // z and p both report a clear tested bit
                flags_out = {bit_test[7], (bit_test == 8'd0), bit_test[5], 1'b1,
                             bit_test[3], (bit_test == 8'd0), 1'b0, cin};
                t_states  = ibsr_pkg::T_BIT;
            end
            ibsr_pkg::GRP_RES:
            begin
                mem_write_value = mem_byte & ~bit_mask;
            end
            default:
            begin
                mem_write_value = mem_byte | bit_mask;
            end
        endcase
    end

endmodule

// ===== rtl/indexed_bit_shift_rotate_unit.sv =====
// an accepted transaction is captured in the input register, then presented on result with done
// throughput: one transaction per cycle; busy stays low, so start may be held high every cycle
// the pipe is an input register, one pass of address and alu logic, then the result register
// the receiver cannot stall: done pulses for exactly one cycle per transaction
// reset (rst_n low, asynchronous) drops all in-flight transactions and clears done
`timescale 1ns / 1ps

`include "indexed_bit_shift_rotate_unit_macros.svh"

module indexed_bit_shift_rotate_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ibsr_pkg::cmd_t    cmd,
    output logic              done,
    output ibsr_pkg::result_t result
);

    // input stage
    logic              accept;
    logic              stage_valid_reg;
    logic              stage_valid_next;
    ibsr_pkg::cmd_t    cmd_reg;
    ibsr_pkg::cmd_t    cmd_next;

    // result stage
    logic              done_reg;
    logic              done_next;
    ibsr_pkg::result_t result_reg;
    ibsr_pkg::result_t result_next;

    // no state is carried between transactions, so a new one is always welcome
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    assign stage_valid_next = accept;
    assign cmd_next         = accept ? cmd : cmd_reg;

    // address path
    ibsr_addr u_addr
    (
        .index_base        (cmd_reg.index_base),
        .displacement      (cmd_reg.displacement),
        .effective_address (result_next.effective_address)
    );

    // data and flag path
    ibsr_alu u_alu
    (
        .sub_opcode       (cmd_reg.sub_opcode),
        .mem_byte         (cmd_reg.mem_byte),
        .flags_in         (cmd_reg.flags_in),
        .mem_write_value  (result_next.mem_write_value),
        .reg_write_enable (result_next.reg_write_enable),
        .reg_dest         (result_next.reg_dest),
        .reg_value        (result_next.reg_value),
        .flags_out        (result_next.flags_out),
        .t_states         (result_next.t_states)
    );

    // the strobe follows the input stage in the next cycle
    assign done_next = stage_valid_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            done_reg        <= done_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // every accepted transaction reaches the input stage
    `IBSR_ASSERT_NEXT(a_accept_to_stage, clk, rst_n, accept, stage_valid_reg, "accepted transaction lost")
    // the input stage always produces a strobe on the next cycle
    `IBSR_ASSERT_NEXT(a_stage_to_done, clk, rst_n, stage_valid_reg, done, "result strobe missing")
    // a strobe never appears without a transaction behind it
    `IBSR_ASSERT_NOW(a_no_spurious_done, clk, rst_n, done, $past(stage_valid_reg), "spurious result strobe")
    // a register copy only comes from a shift or rotate with a real register code
    `IBSR_ASSERT_NOW(a_reg_write_legal, clk, rst_n, done && result.reg_write_enable, (result.reg_dest != ibsr_pkg::REG_MEM) && (result.t_states == ibsr_pkg::T_OTHER), "illegal register write")

endmodule

// ===== tb/indexed_bit_shift_rotate_unit_checker.sv =====
// checker that predicts and compares every transaction of the indexed bit shift rotate unit
`timescale 1ns / 1ps

module indexed_bit_shift_rotate_unit_checker
    import ibsr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  cmd_t    cmd,
    input  logic    done,
    input  result_t result,
    output int      fail_count,
    output int      outstanding
);

    result_t expected_results[$];
    int      mismatches = 0;

    assign fail_count = mismatches;

    // expected outcome of one indexed cb instruction
    function automatic result_t compute_indexed_result(cmd_t c);
        result_t    r;
        group_t     grp;
        logic [2:0] sel;
        logic [7:0] bit_mask;
        logic [7:0] shifted;
        logic [7:0] tested;
        logic       carry_out;
        grp       = group_t'(c.sub_opcode[7:6]);
        sel       = c.sub_opcode[5:3];
        bit_mask  = 8'd1 << sel;
        shifted   = '0;
        carry_out = 1'b0;
        tested    = c.mem_byte & bit_mask;

        r = '0;
        r.effective_address = c.index_base + {{8{c.displacement[7]}}, c.displacement};
        r.mem_write_value   = c.mem_byte;
        r.reg_dest          = c.sub_opcode[2:0];
        r.flags_out         = c.flags_in;
        r.t_states          = T_OTHER;

        case (grp)
            GRP_SHIFT:
            begin
                case (shift_op_t'(sel))
                    SH_RLC: {carry_out, shifted} = {c.mem_byte, c.mem_byte[7]};
                    SH_RRC: {shifted, carry_out} = {c.mem_byte[0], c.mem_byte};
                    SH_RL:  {carry_out, shifted} = {c.mem_byte, c.flags_in[FLAG_C]};
                    SH_RR:  {shifted, carry_out} = {c.flags_in[FLAG_C], c.mem_byte};
                    SH_SLA: {carry_out, shifted} = {c.mem_byte, 1'b0};
                    SH_SRA: {shifted, carry_out} = {c.mem_byte[7], c.mem_byte};
                    SH_SLL: {carry_out, shifted} = {c.mem_byte, 1'b1};
                    default: {shifted, carry_out} = {1'b0, c.mem_byte};
                endcase
                r.mem_write_value   = shifted;
                r.flags_out         = '0;
                r.flags_out[FLAG_S] = shifted[7];
                r.flags_out[FLAG_Z] = (shifted == 8'h00);
                r.flags_out[FLAG_Y] = shifted[5];
                r.flags_out[FLAG_X] = shifted[3];
                r.flags_out[FLAG_P] = ~^shifted;
                r.flags_out[FLAG_C] = carry_out;
                if (c.sub_opcode[2:0] != REG_MEM)
                begin
                    r.reg_write_enable = 1'b1;
                    r.reg_value        = shifted;
                end
            end
            GRP_BIT:
            begin
                r.flags_out         = '0;
                r.flags_out[FLAG_S] = tested[7];
                r.flags_out[FLAG_Z] = (tested == 8'h00);
                r.flags_out[FLAG_Y] = tested[5];
                r.flags_out[FLAG_H] = 1'b1;
                r.flags_out[FLAG_X] = tested[3];
                r.flags_out[FLAG_P] = (tested == 8'h00);
                r.flags_out[FLAG_C] = c.flags_in[FLAG_C];
                r.t_states          = T_BIT;
            end
            GRP_RES: r.mem_write_value = c.mem_byte & ~bit_mask;
            default: r.mem_write_value = c.mem_byte | bit_mask;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [15:0] want, logic [15:0] got);
        $display("%0t: mismatch on %s: expected %h, got %h", $realtime, field, want, got);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with no transaction pending", '0,
                                    result.effective_address);
                else
                begin
                    want = expected_results.pop_front();
                    if (result.effective_address !== want.effective_address)
                        report_mismatch("effective_address", want.effective_address,
                                        result.effective_address);
                    if (result.mem_write_value !== want.mem_write_value)
                        report_mismatch("mem_write_value", 16'(want.mem_write_value),
                                        16'(result.mem_write_value));
                    if (result.reg_write_enable !== want.reg_write_enable)
                        report_mismatch("reg_write_enable", 16'(want.reg_write_enable),
                                        16'(result.reg_write_enable));
                    if (result.reg_dest !== want.reg_dest)
                        report_mismatch("reg_dest", 16'(want.reg_dest), 16'(result.reg_dest));
                    if (result.reg_value !== want.reg_value)
                        report_mismatch("reg_value", 16'(want.reg_value),
                                        16'(result.reg_value));
                    if (result.flags_out !== want.flags_out)
                        report_mismatch("flags_out", 16'(want.flags_out),
                                        16'(result.flags_out));
                    if (result.t_states !== want.t_states)
                        report_mismatch("t_states", 16'(want.t_states), 16'(result.t_states));
                end
            end
            if (start && !busy)
                expected_results.push_back(compute_indexed_result(cmd));
            outstanding <= expected_results.size();
        end
    end

endmodule

// ===== tb/indexed_bit_shift_rotate_unit_test.sv =====
// top of the testbench: clock, reset, stimulus, watchdog and verdict
`timescale 1ns / 1ps

module indexed_bit_shift_rotate_unit_test;
    import ibsr_pkg::*;

    // register codes of the cb group, memory only is REG_MEM from the package
    localparam logic [2:0] REG_B = 3'd0;
    localparam logic [2:0] REG_C = 3'd1;
    localparam logic [2:0] REG_D = 3'd2;
    localparam logic [2:0] REG_E = 3'd3;
    localparam logic [2:0] REG_H = 3'd4;
    localparam logic [2:0] REG_L = 3'd5;
    localparam logic [2:0] REG_A = 3'd7;

    localparam int RANDOM_ITEMS = 1000;
    // longest quiet stretch allowed; it exceeds the longest sender gap
    localparam int IDLE_LIMIT   = 1000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t result;
    int      fail_count;
    int      outstanding;
    int      idle_cycles;

    indexed_bit_shift_rotate_unit i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    indexed_bit_shift_rotate_unit_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .result      (result),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: any accepted transaction or any result keeps the run alive
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic logic [7:0] make_op(group_t grp, logic [2:0] sel, logic [2:0] dest);
        return {grp, sel, dest};
    endfunction

    // present one transaction and hold it until accepted, then idle for the requested gap;
    // start is only lowered when a gap follows, so back to back items keep it high
    task automatic send_cmd(cmd_t c, int gap);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_fields(logic [15:0] base, logic [7:0] disp, logic [7:0] op,
                               logic [7:0] data, logic [7:0] flags);
        cmd_t c;
        c.index_base   = base;
        c.displacement = disp;
        c.sub_opcode   = op;
        c.mem_byte     = data;
        c.flags_in     = flags;
        send_cmd(c, $urandom_range(0, 2));
    endtask

    // mostly short gaps, sometimes a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    // random transaction with extra weight on edge values of the byte and address
    function automatic cmd_t random_cmd();
        cmd_t c;
        c.index_base   = 16'($urandom_range(0, 65535));
        c.displacement = 8'($urandom_range(0, 255));
        c.sub_opcode   = 8'($urandom_range(0, 255));
        c.mem_byte     = 8'($urandom_range(0, 255));
        c.flags_in     = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0: c.mem_byte = 8'h00;
            1: c.mem_byte = 8'hff;
            2: c.mem_byte = $urandom_range(0, 1) ? 8'h80 : 8'h01;
            3: c.index_base = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            4: c.displacement = $urandom_range(0, 1) ? 8'h80 : 8'h7f;
            default: ;
        endcase
        return c;
    endfunction

    initial
    begin
        bit burst;
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: address wrap both ways, every shift with carry in and out,
        // memory only forms, bit test on zero and set bits, res and set at both ends
        send_fields(16'h0000, 8'h80, make_op(GRP_SHIFT, SH_RLC, REG_B), 8'h80, 8'h00);
        send_fields(16'hffff, 8'h7f, make_op(GRP_SHIFT, SH_RRC, REG_C), 8'h01, 8'hff);
        send_fields(16'h8000, 8'h00, make_op(GRP_SHIFT, SH_RL, REG_D), 8'h80, 8'h01);
        send_fields(16'h7fff, 8'h01, make_op(GRP_SHIFT, SH_RL, REG_A), 8'h00, 8'h00);
        send_fields(16'h1234, 8'hff, make_op(GRP_SHIFT, SH_RR, REG_E), 8'h01, 8'h01);
        send_fields(16'h4000, 8'hc0, make_op(GRP_SHIFT, SH_RR, REG_MEM), 8'hfe, 8'h00);
        send_fields(16'h0080, 8'h80, make_op(GRP_SHIFT, SH_SLA, REG_H), 8'hff, 8'h00);
        send_fields(16'hff80, 8'h7f, make_op(GRP_SHIFT, SH_SRA, REG_L), 8'h81, 8'hff);
        send_fields(16'h0001, 8'hfe, make_op(GRP_SHIFT, SH_SLL, REG_MEM), 8'h00, 8'h00);
        send_fields(16'hfffe, 8'h02, make_op(GRP_SHIFT, SH_SLL, REG_A), 8'hff, 8'hff);
        send_fields(16'h5555, 8'h55, make_op(GRP_SHIFT, SH_SRL, REG_B), 8'h01, 8'h00);
        send_fields(16'haaaa, 8'haa, make_op(GRP_SHIFT, SH_RLC, REG_MEM), 8'hff, 8'hff);
        send_fields(16'h0000, 8'h00, make_op(GRP_BIT, 3'd0, REG_MEM), 8'h00, 8'hff);
        send_fields(16'hffff, 8'hff, make_op(GRP_BIT, 3'd7, REG_MEM), 8'h80, 8'h00);
        send_fields(16'h2000, 8'h10, make_op(GRP_BIT, 3'd5, REG_MEM), 8'h20, 8'h01);
        send_fields(16'h3000, 8'hf0, make_op(GRP_BIT, 3'd3, REG_A), 8'hff, 8'hfe);
        send_fields(16'h0100, 8'h80, make_op(GRP_RES, 3'd0, REG_MEM), 8'hff, 8'h5a);
        send_fields(16'hff00, 8'h7f, make_op(GRP_RES, 3'd7, REG_MEM), 8'hff, 8'ha5);
        send_fields(16'h00ff, 8'h01, make_op(GRP_SET, 3'd0, REG_MEM), 8'h00, 8'h00);
        send_fields(16'hff01, 8'hff, make_op(GRP_SET, 3'd7, REG_MEM), 8'h00, 8'hff);
        send_fields(16'h6000, 8'h33, make_op(GRP_RES, 3'd2, REG_L), 8'haa, 8'h11);
        send_fields(16'h9000, 8'hcc, make_op(GRP_SET, 3'd4, REG_C), 8'h55, 8'hee);
        send_fields(16'hffff, 8'hff, make_op(GRP_SHIFT, SH_SRL, REG_MEM), 8'h80, 8'h00);
        send_fields(16'h007f, 8'h80, make_op(GRP_SHIFT, SH_SRA, REG_A), 8'h7f, 8'h01);

        // random part in blocks of 100, some blocks back to back with no gaps
        burst = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
                burst = ($urandom_range(0, 3) == 0);
            send_cmd(random_cmd(), burst ? 0 : pick_gap());
            // hold off halfway until the unit has drained completely
            if (n == RANDOM_ITEMS / 2)
            begin
                start <= 1'b0;
                do
                    @(posedge clk);
                while (outstanding != 0);
            end
        end

        // drain, then keep watching for any stray result to show up
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
